/* rtl/cfb_pkg.sv */
// Package for the command frame bridge.
// Holds shared constants, the request type between the group collector and
// the frame generator, the generator state type and the frame byte function.
package cfb_pkg;

    localparam int BYTE_W      = 8;
    localparam int GROUP_LEN   = 5;
    localparam int GROUP_MEM_D = 4;
    localparam int MEM_AW      = 2;
    localparam int COUNT_W     = 3;
    localparam int FRAME_LEN   = 10;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PARAM_HIGH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_LOW  = 1'd1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'hFE;
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] VER_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] LEN_BYTE   = 8'h06;
    localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hEF;

    localparam logic [MEM_AW-1:0]  CMD_ENTRY  = 2'd2;
    localparam logic [COUNT_W-1:0] LAST_COUNT = 3'(GROUP_LEN - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = 4'(FRAME_LEN - 1);

    localparam logic [IDX_W-1:0] POS_START = 4'd0;
    localparam logic [IDX_W-1:0] POS_VER   = 4'd1;
    localparam logic [IDX_W-1:0] POS_LEN   = 4'd2;
    localparam logic [IDX_W-1:0] POS_CMD   = 4'd3;
    localparam logic [IDX_W-1:0] POS_ACK   = 4'd4;
    localparam logic [IDX_W-1:0] POS_PH    = 4'd5;
    localparam logic [IDX_W-1:0] POS_PL    = 4'd6;
    localparam logic [IDX_W-1:0] POS_CHK_H = 4'd7;
    localparam logic [IDX_W-1:0] POS_CHK_L = 4'd8;

    typedef struct packed {
        logic              pending;
        logic [BYTE_W-1:0] cmd;
    } cfb_req_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } gen_state_t;

    function automatic logic [BYTE_W-1:0] frame_byte(
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] cmd,
        input logic [BYTE_W-1:0] ph,
        input logic [BYTE_W-1:0] pl
    );
        logic [15:0] sum;
        logic [15:0] chk;
        logic [BYTE_W-1:0] res;
        sum = 16'(VER_BYTE) + 16'(LEN_BYTE) + 16'(cmd) + 16'(ph) + 16'(pl);
        chk = 16'd0 - sum;
        case (idx)
            POS_START: res = START_BYTE;
            POS_VER:   res = VER_BYTE;
            POS_LEN:   res = LEN_BYTE;
            POS_CMD:   res = cmd;
            POS_ACK:   res = ACK_BYTE;
            POS_PH:    res = ph;
            POS_PL:    res = pl;
            POS_CHK_H: res = chk[15:8];
            POS_CHK_L: res = chk[7:0];
            default:   res = END_BYTE;
        endcase
        return res;
    endfunction

endpackage

/* rtl/cfb_group_mem.sv */
// Group collector of the command frame bridge.
// Stores received bytes in a four-entry memory, tracks the header match and
// posts one frame request per matching group. Depends on cfb_pkg.
module cfb_group_mem
    import cfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output cfb_req_t          req,
    input  logic              req_take
);

    logic [BYTE_W-1:0]  mem [GROUP_MEM_D];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               match_reg;
    logic               match_next;
    logic               pending_reg;
    logic               pending_next;
    logic               accept;
    logic               at_last;
    logic               group_ok;

    assign at_last  = (count_reg == LAST_COUNT);
    assign in_ready = !(at_last && pending_reg);
    assign accept   = in_valid && in_ready;
    assign group_ok = match_reg && (rx_byte == TAIL_BYTE);

    always_comb
    begin
        count_next   = count_reg;
        match_next   = match_reg;
        pending_next = pending_reg;
        if (req_take)
        begin
            pending_next = 1'b0;
        end
        if (accept)
        begin
            if (at_last)
            begin
                count_next = '0;
                if (group_ok)
                begin
                    pending_next = 1'b1;
                end
            end
            else
            begin
                count_next = count_reg + 3'd1;
            end
            case (count_reg)
                3'd0:    match_next = (rx_byte == SYNC_BYTE);
                3'd1:    match_next = match_reg && (rx_byte == SYNC_BYTE);
                3'd3:    match_next = match_reg && (rx_byte == TAIL_BYTE);
                default: match_next = match_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            match_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            match_reg   <= match_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !at_last)
        begin
            mem[count_reg[MEM_AW-1:0]] <= rx_byte;
        end
        if (accept && at_last)
        begin
            rd_data_reg <= mem[CMD_ENTRY];
        end
    end

    assign req.pending = pending_reg;
    assign req.cmd     = rd_data_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_COUNT)
        else $error("group count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept && at_last |-> !pending_reg)
        else $error("group completed while a request is still pending");

    a_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> pending_reg)
        else $error("request taken while none is pending");

    a_post: assert property (@(posedge clk) disable iff (!rst_n)
        accept && at_last && group_ok |=> pending_reg && count_reg == '0)
        else $error("matching group did not post a request");

endmodule

/* rtl/cfb_frame_gen.sv */
// Frame generator of the command frame bridge.
// Takes frame requests and sends the ten frame bytes through an output
// register, one byte per cycle while the sink takes them. Depends on cfb_pkg.
module cfb_frame_gen
    import cfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfb_req_t          req,
    output logic              req_take,
    input  logic [BYTE_W-1:0] param_high,
    input  logic [BYTE_W-1:0] param_low,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] tx_byte,
    output logic              frame_end
);

    gen_state_t        state_reg;
    gen_state_t        state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [BYTE_W-1:0] cmd_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic              frame_end_reg;
    logic              advance;
    logic              last_byte;

    assign last_byte = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.pending)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (advance && last_byte && !req.pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        advance        = 1'b0;
        req_take       = 1'b0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                req_take = req.pending;
                idx_next = '0;
            end
            ST_SEND:
            begin
                advance = !out_valid_reg || out_ready;
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    if (last_byte)
                    begin
                        req_take = req.pending;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg <= req.cmd;
        end
        if (advance)
        begin
            tx_byte_reg   <= frame_byte(idx_reg, cmd_reg, param_high, param_low);
            frame_end_reg <= last_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> tx_byte == END_BYTE)
        else $error("frame end flag without end marker");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> idx_reg == '0)
        else $error("byte index not cleared while idle");

    a_take_bound: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == ST_SEND && idx_reg == '0)
        else $error("frame request taken without starting a frame");

endmodule

/* rtl/command_frame_bridge.sv */
// Command frame bridge: one received byte per cycle while in_ready is high; a
// matching five-byte group gives a ten-byte frame: the request is registered,
// the generator takes it, and the first byte leaves its output register, then
// one byte per cycle while the sink takes them. The generator bounds the
// sustained input rate; one request waits while a frame is sent.
// Reset clears group count, byte index, flags, state and parameter registers.
module command_frame_bridge
    import cfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    tx_byte,
    output logic                 frame_end
);

    logic [BYTE_W-1:0] param_high_reg;
    logic [BYTE_W-1:0] param_low_reg;
    cfb_req_t          req;
    logic              req_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_high_reg <= '0;
            param_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PARAM_HIGH: param_high_reg <= cfg_data;
                REG_PARAM_LOW:  param_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    cfb_group_mem u_group
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .req      (req),
        .req_take (req_take)
    );

    cfb_frame_gen u_gen
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_take   (req_take),
        .param_high (param_high_reg),
        .param_low  (param_low_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_byte    (tx_byte),
        .frame_end  (frame_end)
    );

endmodule

/* test/command_frame_bridge_check.sv */
// Checker for the command frame bridge: watches the config port and both byte
// channels, predicts every command frame and compares each transmitted byte.
// Depends on cfb_pkg for widths, register indexes and frame constants.
`timescale 1ns / 100ps

module command_frame_bridge_check
    import cfb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [BYTE_W-1:0]    tx_byte,
    input  logic                 frame_end,
    output int                   errors,
    output int                   bytes_owed,
    output int                   frames_checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } tx_item_t;

    logic [BYTE_W-1:0]  held [GROUP_MEM_D];
    logic [COUNT_W-1:0] held_count;
    logic [BYTE_W-1:0]  param_high;
    logic [BYTE_W-1:0]  param_low;
    tx_item_t           frame_due [$];
    int                 error_total;
    int                 frame_total;

    task automatic collect_rx_byte(input logic [BYTE_W-1:0] b);
        logic [15:0]       chk;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] frame [FRAME_LEN];
        if (held_count < LAST_COUNT)
        begin
            held[held_count[MEM_AW-1:0]] = b;
            held_count = held_count + 3'd1;
        end
        else
        begin
            held_count = '0;
            if (held[0] == SYNC_BYTE && held[1] == SYNC_BYTE &&
                held[3] == TAIL_BYTE && b == TAIL_BYTE)
            begin
                cmd = held[CMD_ENTRY];
                chk = 16'd0 - (16'(VER_BYTE) + 16'(LEN_BYTE) + 16'(cmd) +
                               16'(param_high) + 16'(param_low));
                frame = '{START_BYTE, VER_BYTE, LEN_BYTE, cmd, ACK_BYTE,
                          param_high, param_low, chk[15:8], chk[7:0], END_BYTE};
                for (int k = 0; k < FRAME_LEN; k++)
                    frame_due.push_back(tx_item_t'{frame[k], k == FRAME_LEN - 1});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tx_item_t want;
        if (!rst_n)
        begin
            held_count = '0;
            param_high = '0;
            param_low = '0;
            foreach (held[i])
                held[i] = '0;
            frame_due.delete();
            error_total = 0;
            frame_total = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PARAM_HIGH: param_high = cfg_data;
                    REG_PARAM_LOW:  param_low = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (frame_due.size() == 0)
                begin
                    $error("tx_byte: expected none, actual %02h", tx_byte);
                    error_total++;
                end
                else
                begin
                    want = frame_due.pop_front();
                    if (tx_byte !== want.data)
                    begin
                        $error("tx_byte: expected %02h, actual %02h", want.data, tx_byte);
                        error_total++;
                    end
                    if (frame_end !== want.last)
                    begin
                        $error("frame_end: expected %0b, actual %0b", want.last, frame_end);
                        error_total++;
                    end
                    if (want.last)
                        frame_total++;
                end
            end
            if (in_valid && in_ready)
                collect_rx_byte(rx_byte);
        end
        errors <= error_total;
        bytes_owed <= frame_due.size();
        frames_checked <= frame_total;
    end

endmodule

/* test/command_frame_bridge_test.sv */
// Top of the command frame bridge testbench: clock, reset, byte stimulus,
// receiver stalls, parameter writes and the verdict.
// Depends on cfb_pkg, command_frame_bridge and command_frame_bridge_check.
`timescale 1ns / 100ps

module command_frame_bridge_test;
    import cfb_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int GROUPS_PER_PHASE = 14;

    typedef logic [0:GROUP_LEN-1][BYTE_W-1:0] group_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    tx_byte;
    logic                 frame_end;

    int errors;
    int bytes_owed;
    int frames_checked;
    int burst_left;
    int bytes_sent;
    int groups_sent;
    int settings_used;
    int idle_cycles;
    int stall_mode;
    int stall_phase;

    command_frame_bridge uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .frame_end (frame_end)
    );

    command_frame_bridge_check frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .frame_end      (frame_end),
        .errors         (errors),
        .bytes_owed     (bytes_owed),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (stall_phase <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 80);
        end
        stall_phase--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 5) == 0);
            default: out_ready <= (stall_phase % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_rx(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                rx_byte <= 8'($urandom);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_group(input group_t g);
        for (int i = 0; i < GROUP_LEN; i++)
            send_rx(g[i]);
        groups_sent++;
    endtask

    task automatic send_random_group();
        group_t g;
        int pos;
        g = {SYNC_BYTE, SYNC_BYTE, 8'($urandom), TAIL_BYTE, TAIL_BYTE};
        case ($urandom_range(0, 9))
            7, 8:
            begin
                pos = $urandom_range(0, 3);
                if (pos >= CMD_ENTRY)
                    pos++;
                g[pos] = g[pos] ^ 8'($urandom_range(1, 255));
            end
            9: g = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            default: ;
        endcase
        send_group(g);
    endtask

    // The block may still be judging a group that gives no frame, so the task
    // waits on past the last expected byte before the registers change.
    task automatic set_params(input logic [BYTE_W-1:0] ph, input logic [BYTE_W-1:0] pl);
        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_PARAM_HIGH;
        cfg_data <= ph;
        @(negedge clk);
        cfg_index <= REG_PARAM_LOW;
        cfg_data <= pl;
        @(negedge clk);
        cfg_we <= 1'b0;
        burst_left = 0;
        settings_used++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PARAM_HIGH;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        burst_left = 0;
        bytes_sent = 0;
        groups_sent = 0;
        settings_used = 1;
        stall_phase = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_group({SYNC_BYTE, SYNC_BYTE, 8'h00, TAIL_BYTE, TAIL_BYTE});
        send_group({SYNC_BYTE, SYNC_BYTE, 8'h55, TAIL_BYTE, 8'hFD});
        send_group({SYNC_BYTE, SYNC_BYTE, 8'hFF, TAIL_BYTE, TAIL_BYTE});
        set_params(8'hFF, 8'hFF);
        send_group({SYNC_BYTE, SYNC_BYTE, 8'h80, TAIL_BYTE, TAIL_BYTE});
        send_group({8'h00, SYNC_BYTE, 8'h12, TAIL_BYTE, TAIL_BYTE});

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_params(8'($urandom), 8'($urandom));
                1: set_params(8'hFF, 8'h00);
                2: set_params(8'h00, 8'h00);
                default: set_params(8'h00, 8'hFF);
            endcase
            repeat (GROUPS_PER_PHASE) send_random_group();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d groups under %0d parameter settings.",
                 bytes_sent, groups_sent, settings_used);
        $display("Checked %0d command frames byte by byte.", frames_checked);
        if (errors == 0 && bytes_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
